### hw/rtl/median9_smoothing_filter_core_assert.svh
// assertion macros shared by the median smoother rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MEDIAN9_SMOOTHING_FILTER_CORE_ASSERT_SVH
`define MEDIAN9_SMOOTHING_FILTER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define M9_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define M9_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/med9_pkg.sv
// shared constants, types and the median network for the median smoother
// no dependencies
package med9_pkg;

  localparam int CHANNELS   = 4;
  localparam int WIN        = 9;
  localparam int CH_W       = 2;
  localparam int SMP_W      = 13;
  localparam int CNT_W      = 4;
  localparam int BANKS      = 2;
  localparam int RAM_DEPTH  = CHANNELS * BANKS * WIN;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);
  localparam int RD_SLOTS   = WIN - 1;
  localparam int JOBQ_DEPTH = 4;
  localparam int JQ_PTR_W   = $clog2(JOBQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RQ_PTR_W   = $clog2(RESQ_DEPTH);
  localparam int SUM_W      = SMP_W + 3;

  typedef logic [CH_W-1:0] ch_t;
  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [WIN-1:0][SMP_W-1:0] win_t;

  // one completed window waiting for the median unit
  typedef struct packed {
    ch_t  ch;
    logic bank;
    smp_t sample;
  } job_t;

  // window ram write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    smp_t              data;
  } ram_wr_t;

  // bank release from the read side
  typedef struct packed {
    logic valid;
    ch_t  ch;
    logic bank;
  } rel_t;

  typedef struct packed {
    ch_t  ch;
    smp_t median;
    smp_t smoothed;
  } res_t;

  // ram address of one slot of one bank of one channel
  function automatic logic [ADDR_W-1:0] ram_addr(ch_t ch, logic bank, cnt_t slot);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(ch) * ADDR_W'(BANKS * WIN) + ADDR_W'(bank) * ADDR_W'(WIN) + ADDR_W'(slot);
    return a;
  endfunction

  // order two elements so the smaller sits at index a
  function automatic win_t cswap(win_t w, int unsigned a, int unsigned b);
    win_t r;
    r = w;
    if ($signed(w[a]) > $signed(w[b])) begin
      r[a] = w[b];
      r[b] = w[a];
    end
    return r;
  endfunction

  // network layers one to three
  function automatic win_t net_a(win_t w);
    win_t r;
    r = w;
    r = cswap(r, 1, 2); r = cswap(r, 4, 5); r = cswap(r, 7, 8);
    r = cswap(r, 0, 1); r = cswap(r, 3, 4); r = cswap(r, 6, 7);
    r = cswap(r, 1, 2); r = cswap(r, 4, 5); r = cswap(r, 7, 8);
    return r;
  endfunction

  // network layers four to six
  function automatic win_t net_b(win_t w);
    win_t r;
    r = w;
    r = cswap(r, 0, 3); r = cswap(r, 5, 8); r = cswap(r, 4, 7);
    r = cswap(r, 3, 6); r = cswap(r, 1, 4); r = cswap(r, 2, 5);
    r = cswap(r, 4, 7);
    return r;
  endfunction

  // last three steps, median lands in the middle slot
  function automatic smp_t net_c(win_t w);
    win_t r;
    r = w;
    r = cswap(r, 4, 2);
    r = cswap(r, 6, 4);
    r = cswap(r, 4, 2);
    return smp_t'(r[4]);
  endfunction

endpackage

### hw/rtl/median9_smoothing_filter_core.sv
// top level of the nine-sample median smoother
// depends on med9_pkg, med9_ram, med9_front, med9_jobq, med9_back and the assert header
//
// Accepts one tagged sample per cycle while full is low. Each channel fills a nine-sample
// window; the first eight samples go to a double-banked window ram, and the ninth hands
// the window to the back end through a four-entry queue. The back end reads the eight
// stored slots through the single ram read port, one per cycle while the output queue has
// room, then runs the compare-swap network in three registered steps and smooths the
// median in one more. A result waits in a two-entry output queue. full rises only when
// the window queue is full or a channel completes a bank before the previous window of
// that channel was read out; while the output queue is full the back end stalls. A
// channel number of CHANNELS or more is dropped. The window ram needs no clearing after
// reset.
`include "median9_smoothing_filter_core_assert.svh"

module median9_smoothing_filter_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  med9_pkg::ch_t  channel_i,
  input  med9_pkg::smp_t sample_i,
  output logic           empty,
  input  logic           pop,
  output med9_pkg::ch_t  out_channel_o,
  output med9_pkg::smp_t median_o,
  output med9_pkg::smp_t smoothed_o
);
  import med9_pkg::*;

  ram_wr_t           ram_wr;
  logic              job_push;
  job_t              job;
  job_t              jq_head;
  logic              jq_full;
  logic              jq_empty;
  logic              jq_pop;
  rel_t              rel;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  smp_t              rdata;
  res_t              res;

  // sample intake
  med9_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .channel_i  (channel_i),
    .sample_i   (sample_i),
    .jq_full_i  (jq_full),
    .rel_i      (rel),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job),
    .wr_o       (ram_wr)
  );

  // window storage
  med9_ram #(
    .WIDTH (SMP_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // completed windows
  med9_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job),
    .pop_i   (jq_pop),
    .head_o  (jq_head),
    .full_o  (jq_full),
    .empty_o (jq_empty)
  );

  // median and smoothing
  med9_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .jq_empty_i (jq_empty),
    .jq_head_i  (jq_head),
    .jq_pop_o   (jq_pop),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rdata_i    (rdata),
    .rel_o      (rel),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign out_channel_o = res.ch;
  assign median_o      = res.median;
  assign smoothed_o    = res.smoothed;

  // checks
  `M9_ASSERT_IMP(a_full_blocks_intake, push && full, !ram_wr.en && !job_push, "sample taken while full")
  `M9_ASSERT_IMP(a_ninth_not_stored, job_push, !ram_wr.en, "ninth sample written to window ram")
  `M9_ASSERT_IMP(a_release_disjoint, rel.valid && job_push, (rel.ch != job.ch) || (rel.bank != job.bank), "bank released and completed together")
  `M9_ASSERT_IMP(a_jobq_pop_nonempty, jq_pop, !jq_empty, "window queue popped while empty")

endmodule

### hw/rtl/med9_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module med9_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/med9_front.sv
// front end: takes samples, keeps per-channel fill counts and bank flags
// depends on med9_pkg
module med9_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  med9_pkg::ch_t      channel_i,
  input  med9_pkg::smp_t     sample_i,
  input  logic               jq_full_i,
  input  med9_pkg::rel_t     rel_i,
  output logic               full_o,
  output logic               job_push_o,
  output med9_pkg::job_t     job_o,
  output med9_pkg::ram_wr_t  wr_o
);
  import med9_pkg::*;

  cnt_t             count_q [CHANNELS];
  cnt_t             count_d [CHANNELS];
  logic             bank_q  [CHANNELS];
  logic             bank_d  [CHANNELS];
  logic [BANKS-1:0] pend_q  [CHANNELS];
  logic [BANKS-1:0] pend_d  [CHANNELS];
  logic             hazard;
  logic             in_range;
  logic             accept;
  logic             last;

  // a channel filling a bank that is still being read blocks input
  always_comb begin
    hazard = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      hazard = hazard | pend_q[c][bank_q[c]];
    end
  end

  assign full_o   = jq_full_i | hazard;
  assign in_range = int'(channel_i) < CHANNELS;
  assign accept   = push_i & ~full_o & in_range;
  assign last     = count_q[channel_i] == CNT_W'(WIN - 1);

  // first eight samples go to the ram, the ninth rides with the job
  assign wr_o.en   = accept & ~last;
  assign wr_o.addr = ram_addr(channel_i, bank_q[channel_i], count_q[channel_i]);
  assign wr_o.data = sample_i;

  assign job_push_o  = accept & last;
  assign job_o.ch     = channel_i;
  assign job_o.bank   = bank_q[channel_i];
  assign job_o.sample = sample_i;

  // count, bank and pending updates
  always_comb begin
    count_d = count_q;
    bank_d  = bank_q;
    pend_d  = pend_q;
    if (rel_i.valid) begin
      pend_d[rel_i.ch][rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (last) begin
        count_d[channel_i] = '0;
        bank_d[channel_i]  = ~bank_q[channel_i];
        pend_d[channel_i][bank_q[channel_i]] = 1'b1;
      end else begin
        count_d[channel_i] = count_q[channel_i] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        count_q[c] <= '0;
        bank_q[c]  <= 1'b0;
        pend_q[c]  <= '0;
      end
    end else begin
      count_q <= count_d;
      bank_q  <= bank_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### hw/rtl/med9_jobq.sv
// short queue of completed windows between front and back
// depends on med9_pkg
module med9_jobq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  med9_pkg::job_t  job_i,
  input  logic            pop_i,
  output med9_pkg::job_t  head_o,
  output logic            full_o,
  output logic            empty_o
);
  import med9_pkg::*;

  job_t                mem_q [JOBQ_DEPTH];
  logic [JQ_PTR_W-1:0] wptr_q, wptr_d;
  logic [JQ_PTR_W-1:0] rptr_q, rptr_d;
  logic [JQ_PTR_W:0]   cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = cnt_q == (JQ_PTR_W + 1)'(JOBQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rptr_q];

  // pointer and fill updates
  always_comb begin
    wptr_d = do_push ? wptr_q + JQ_PTR_W'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + JQ_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (JQ_PTR_W + 1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - (JQ_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

### hw/rtl/med9_back.sv
// back end: reads a window, runs the median network, smooths, queues results
// depends on med9_pkg
module med9_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        jq_empty_i,
  input  med9_pkg::job_t              jq_head_i,
  output logic                        jq_pop_o,
  output logic                        rd_en_o,
  output logic [med9_pkg::ADDR_W-1:0] rd_addr_o,
  input  med9_pkg::smp_t              rdata_i,
  output med9_pkg::rel_t              rel_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output med9_pkg::res_t              res_o
);
  import med9_pkg::*;

  logic                             en;
  logic                             rq_full;
  logic                             active_q, active_d;
  cnt_t                             slot_q, slot_d;
  job_t                             job_q, job_d;
  job_t                             cur_job;
  cnt_t                             cur_slot;
  logic                             start;
  logic                             issue;
  logic                             last_issue;
  logic                             rv_q, rlast_q;
  ch_t                              meta_ch_q;
  smp_t                             meta_smp_q;
  logic [RD_SLOTS-2:0][SMP_W-1:0]   win_q;
  win_t                             full_win;
  logic                             s1_v_q, s2_v_q, s3_v_q;
  win_t                             s1_w_q, s2_w_q;
  ch_t                              s1_ch_q, s2_ch_q, s3_ch_q;
  smp_t                             s3_med_q;
  smp_t                             smooth_q [CHANNELS];
  logic                             primed_q [CHANNELS];
  smp_t                             old_val;
  logic signed [SUM_W-1:0]          sum;
  smp_t                             sm_val;
  logic                             res_push;
  logic                             res_pop;
  res_t                             rq_mem_q [RESQ_DEPTH];
  logic [RQ_PTR_W-1:0]              rq_wptr_q, rq_rptr_q;
  logic [RQ_PTR_W:0]                rq_cnt_q, rq_cnt_d;

  // whole back end advances only while the result queue has room
  assign en = ~rq_full;

  // read sequencer: eight slots per window
  assign start      = en & ~active_q & ~jq_empty_i;
  assign issue      = start | (en & active_q);
  assign cur_job    = active_q ? job_q : jq_head_i;
  assign cur_slot   = active_q ? slot_q : '0;
  assign last_issue = issue & (cur_slot == CNT_W'(RD_SLOTS - 1));

  assign jq_pop_o   = start;
  assign rd_en_o    = issue;
  assign rd_addr_o  = ram_addr(cur_job.ch, cur_job.bank, cur_slot);
  assign rel_o.valid = last_issue;
  assign rel_o.ch    = cur_job.ch;
  assign rel_o.bank  = cur_job.bank;

  always_comb begin
    active_d = active_q;
    slot_d   = slot_q;
    job_d    = job_q;
    if (issue) begin
      active_d = ~last_issue;
      slot_d   = cur_slot + CNT_W'(1);
      job_d    = cur_job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rv_q     <= 1'b0;
      rlast_q  <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      if (en) begin
        rv_q    <= issue;
        rlast_q <= last_issue;
        s1_v_q  <= rv_q & rlast_q;
        s2_v_q  <= s1_v_q;
        s3_v_q  <= s2_v_q;
      end
    end
  end

  // window assembly: seven slots shifted in, eighth straight from the ram
  assign full_win = {meta_smp_q, rdata_i, win_q};

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    job_q  <= job_d;
    if (en) begin
      if (last_issue) begin
        meta_ch_q  <= cur_job.ch;
        meta_smp_q <= cur_job.sample;
      end
      if (rv_q && !rlast_q) begin
        win_q <= {rdata_i, win_q[RD_SLOTS-2:1]};
      end
      // median network, three registered steps
      s1_w_q   <= net_a(full_win);
      s1_ch_q  <= meta_ch_q;
      s2_w_q   <= net_b(s1_w_q);
      s2_ch_q  <= s1_ch_q;
      s3_med_q <= net_c(s2_w_q);
      s3_ch_q  <= s2_ch_q;
    end
  end

  // smoothing: floor((old*3 + median) / 4), or load on first median
  assign old_val  = smooth_q[s3_ch_q];
  assign sum      = (SUM_W'(old_val) <<< 1) + SUM_W'(old_val) + SUM_W'(s3_med_q);
  assign sm_val   = primed_q[s3_ch_q] ? smp_t'(sum[SMP_W+1:2]) : s3_med_q;
  assign res_push = en & s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        primed_q[c] <= 1'b0;
      end
    end else if (res_push) begin
      primed_q[s3_ch_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      smooth_q[s3_ch_q] <= sm_val;
    end
  end

  // two-entry result queue
  assign rq_full = rq_cnt_q == (RQ_PTR_W + 1)'(RESQ_DEPTH);
  assign empty_o = rq_cnt_q == '0;
  assign res_pop = pop_i & ~empty_o;
  assign res_o   = rq_mem_q[rq_rptr_q];

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    if (res_push && !res_pop) begin
      rq_cnt_d = rq_cnt_q + (RQ_PTR_W + 1)'(1);
    end else if (!res_push && res_pop) begin
      rq_cnt_d = rq_cnt_q - (RQ_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wptr_q <= '0;
      rq_rptr_q <= '0;
      rq_cnt_q  <= '0;
    end else begin
      rq_cnt_q <= rq_cnt_d;
      if (res_push) begin
        rq_wptr_q <= rq_wptr_q + RQ_PTR_W'(1);
      end
      if (res_pop) begin
        rq_rptr_q <= rq_rptr_q + RQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rq_mem_q[rq_wptr_q].ch       <= s3_ch_q;
      rq_mem_q[rq_wptr_q].median   <= s3_med_q;
      rq_mem_q[rq_wptr_q].smoothed <= sm_val;
    end
  end

endmodule

### bench/tb_median9_smoothing_filter_core.sv
// self-checking bench for the nine-sample median smoother core
// depends on med9_pkg and median9_smoothing_filter_core from the rtl folder
module tb_median9_smoothing_filter_core;
  import med9_pkg::*;

  localparam smp_t SMP_MIN     = smp_t'(-4096);
  localparam smp_t SMP_MAX     = smp_t'(4095);
  localparam int   RAND_ITEMS  = 1925;
  localparam int   CALM_ITEMS  = 150;
  localparam int   HOLD_CYCLES = 500;
  localparam int   DRAIN_WAIT  = 40;
  localparam int   QUIET_LIMIT = 4000;

  // compare-swap pairs of the nine-input median network, smaller value to the CS_LO slot
  localparam logic [0:18][3:0] CS_LO = {4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4,
                                        4'd7, 4'd0, 4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4,
                                        4'd4, 4'd6, 4'd4};
  localparam logic [0:18][3:0] CS_HI = {4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5,
                                        4'd8, 4'd3, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7,
                                        4'd2, 4'd4, 4'd2};

  typedef struct packed {
    bit   typed;
    ch_t  ch;
    smp_t smp;
    smp_t med;
    smp_t sm;
  } dir_row_t;

  // directed rows: two full windows at the extremes, then partial windows
  dir_row_t dir_rows [25] = '{
    '{1'b0, 2'd0, SMP_MIN, 13'sd0, 13'sd0}, '{1'b0, 2'd1, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b0, 2'd0, SMP_MIN, 13'sd0, 13'sd0}, '{1'b0, 2'd1, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b0, 2'd0, SMP_MIN, 13'sd0, 13'sd0}, '{1'b0, 2'd1, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b0, 2'd0, SMP_MIN, 13'sd0, 13'sd0}, '{1'b0, 2'd1, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b0, 2'd0, SMP_MIN, 13'sd0, 13'sd0}, '{1'b0, 2'd1, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b0, 2'd0, SMP_MIN, 13'sd0, 13'sd0}, '{1'b0, 2'd1, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b0, 2'd0, SMP_MIN, 13'sd0, 13'sd0}, '{1'b0, 2'd1, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b0, 2'd0, SMP_MIN, 13'sd0, 13'sd0}, '{1'b0, 2'd1, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b1, 2'd0, SMP_MIN, SMP_MIN, SMP_MIN}, '{1'b1, 2'd1, SMP_MAX, SMP_MAX, SMP_MAX},
    '{1'b0, 2'd2, 13'sd0, 13'sd0, 13'sd0}, '{1'b0, 2'd3, -13'sd1, 13'sd0, 13'sd0},
    '{1'b0, 2'd2, 13'sh0AAA, 13'sd0, 13'sd0}, '{1'b0, 2'd3, 13'sh1555, 13'sd0, 13'sd0},
    '{1'b0, 2'd2, 13'sd1, 13'sd0, 13'sd0}, '{1'b0, 2'd3, SMP_MAX, 13'sd0, 13'sd0},
    '{1'b0, 2'd2, SMP_MIN, 13'sd0, 13'sd0}
  };

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic push      = 1'b0;
  logic pop       = 1'b0;
  ch_t  channel_i = '0;
  smp_t sample_i  = '0;
  logic full;
  logic empty;
  ch_t  out_channel_o;
  smp_t median_o;
  smp_t smoothed_o;

  // side band that travels with each item: hand-written expectation, if any
  bit   row_typed = 1'b0;
  smp_t row_med   = '0;
  smp_t row_sm    = '0;

  // predictor state
  smp_t        win_q    [CHANNELS][WIN];
  int unsigned fill_cnt [CHANNELS];
  smp_t        smooth_q [CHANNELS];
  bit          primed_q [CHANNELS];

  res_t pending_results [$];
  int   fails         = 0;
  int   samples_in    = 0;
  int   results_seen  = 0;
  int   stall_cycles  = 0;
  int   quiet_cycles  = 0;
  bit   calm_tail     = 1'b0;

  median9_smoothing_filter_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .channel_i    (channel_i),
    .sample_i     (sample_i),
    .empty        (empty),
    .pop          (pop),
    .out_channel_o(out_channel_o),
    .median_o     (median_o),
    .smoothed_o   (smoothed_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // window fill, median network and smoothing update for one sample
  function automatic bit median_smooth_predict(input ch_t ch, input smp_t smp,
                                               output res_t r);
    int v [WIN];
    int t;
    int acc;
    int sm;
    r = '0;
    if (int'(ch) >= CHANNELS) return 1'b0;
    win_q[ch][fill_cnt[ch]] = smp;
    fill_cnt[ch]++;
    if (fill_cnt[ch] < WIN) return 1'b0;
    fill_cnt[ch] = 0;
    for (int k = 0; k < WIN; k++) v[k] = int'(win_q[ch][k]);
    for (int k = 0; k < 19; k++) begin
      if (v[CS_LO[k]] > v[CS_HI[k]]) begin
        t = v[CS_LO[k]];
        v[CS_LO[k]] = v[CS_HI[k]];
        v[CS_HI[k]] = t;
      end
    end
    // first median loads directly, later ones weigh the old value three quarters
    if (primed_q[ch]) begin
      acc = int'(smooth_q[ch]) * 3 + v[4];
      sm  = acc >>> 2;
    end else begin
      sm = v[4];
      primed_q[ch] = 1'b1;
    end
    smooth_q[ch] = smp_t'(sm);
    r.ch       = ch;
    r.median   = smp_t'(v[4]);
    r.smoothed = smp_t'(sm);
    return 1'b1;
  endfunction

  // accepted items feed the predictor, accepted results are checked in order
  always @(posedge clk_i) begin
    res_t pred;
    res_t exp_r;
    bit   made;
    if (rst_ni && push && full) stall_cycles++;
    if (rst_ni && push && !full) begin
      samples_in++;
      made = median_smooth_predict(channel_i, sample_i, pred);
      if (row_typed) begin
        exp_r.ch       = channel_i;
        exp_r.median   = row_med;
        exp_r.smoothed = row_sm;
        pending_results.push_back(exp_r);
      end else if (made) begin
        pending_results.push_back(pred);
      end
    end
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: channel %0d median %0d smoothed %0d",
               out_channel_o, median_o, smoothed_o);
        fails++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_channel_o !== exp_r.ch) begin
          $error("out_channel mismatch: expected %0d, got %0d", exp_r.ch, out_channel_o);
          fails++;
        end
        if (median_o !== exp_r.median) begin
          $error("median mismatch: expected %0d, got %0d", exp_r.median, median_o);
          fails++;
        end
        if (smoothed_o !== exp_r.smoothed) begin
          $error("smoothed mismatch: expected %0d, got %0d", exp_r.smoothed, smoothed_o);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one item with an occasional idle burst ahead of it
  task automatic offer_sample(input ch_t ch, input smp_t smp, input bit typed,
                              input smp_t med, input smp_t sm);
    if (!calm_tail && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push      <= 1'b1;
    channel_i <= ch;
    sample_i  <= smp;
    row_typed <= typed;
    row_med   <= med;
    row_sm    <= sm;
    do @(posedge clk_i); while (full);
  endtask

  // sender: reset, directed rows, random samples, drain
  initial begin
    ch_t  ch;
    smp_t smp;
    int   pause_at;
    ch = '0;
    pause_at = $urandom_range(900, 1200);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      offer_sample(dir_rows[i].ch, dir_rows[i].smp, dir_rows[i].typed,
                   dir_rows[i].med, dir_rows[i].sm);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i >= RAND_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
      // hold back until the block has handed out every pending result
      if (i == pause_at) begin
        push <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      // channel runs now and then, to fill one channel's banks back to back
      if ($urandom_range(0, 3) != 0) ch = ch_t'($urandom_range(0, (1 << CH_W) - 1));
      case ($urandom_range(0, 9))
        0:       smp = SMP_MIN;
        1:       smp = SMP_MAX;
        2, 3:    smp = smp_t'(int'($urandom_range(0, 6)) - 3);
        default: smp = smp_t'($urandom_range(0, (1 << SMP_W) - 1));
      endcase
      offer_sample(ch, smp, 1'b0, '0, '0);
    end

    push      <= 1'b0;
    row_typed <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fails++;
    end

    $display("run covered %0d samples on all channel codes and %0d median results",
             samples_in, results_seen);
    $display("input held off by full for %0d cycles", stall_cycles);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random pop bursts, one long hold-off to back the block up
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen >= 50) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/med9_pkg.sv
hw/rtl/med9_ram.sv
hw/rtl/med9_front.sv
hw/rtl/med9_jobq.sv
hw/rtl/med9_back.sv
hw/rtl/median9_smoothing_filter_core.sv
bench/tb_median9_smoothing_filter_core.sv
